@@ hdl/mesopic_scotopic_color_adjust_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the night-vision color adjust block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef MESOPIC_SCOTOPIC_COLOR_ADJUST_DEFINES_SVH
`define MESOPIC_SCOTOPIC_COLOR_ADJUST_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication check
`define MSCA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("msca same-cycle check failed");
// next-cycle implication check
`define MSCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msca next-cycle check failed");
`else
`define MSCA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MSCA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hdl/msca_pkg.sv @@
// ---------------------------------------------------------------------------
// msca_pkg
// Types, widths and constants shared by the night-vision color adjust block.
// ---------------------------------------------------------------------------
package msca_pkg;

   // number formats
   localparam int PIXEL_FRAC_BITS = 16;
   localparam int COEF_FRAC_BITS  = 14;
   localparam int PIX_W           = 32;
   localparam int COEF_W          = 16;
   localparam int CRD_W           = 16;

   // configuration port
   localparam int CSR_W      = 3 * COEF_W;
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_LUM_WEIGHTS = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_XYZ_ROW_X   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_XYZ_ROW_Y   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_XYZ_ROW_Z   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRAY_LEVEL  = 3'd4;
   localparam logic [PIX_W-1:0] GRAY_RESET = PIX_W'(longint'(1) << PIXEL_FRAC_BITS);

   // luminance
   localparam int LUM_PROD_W = COEF_W + PIX_W;
   localparam int LUM_SUM_W  = LUM_PROD_W + 2;
   localparam int LUM_W      = LUM_SUM_W - COEF_FRAC_BITS;
   localparam longint LUM_HI_VAL = ((longint'(562) << PIXEL_FRAC_BITS) + 50) / 100;
   localparam longint LUM_LO_VAL = ((longint'(562) << PIXEL_FRAC_BITS) + 50000) / 100000;
   localparam logic [LUM_W-1:0] LUM_HI = LUM_W'(LUM_HI_VAL);
   localparam logic [LUM_W-1:0] LUM_LO = LUM_W'(LUM_LO_VAL);

   // color matrix
   localparam int XYZ_PROD_W = COEF_W + PIX_W + 1;
   localparam int XYZ_SUM_W  = XYZ_PROD_W + 2;
   localparam int XYZ_W      = XYZ_SUM_W - COEF_FRAC_BITS;
   localparam int S_W        = XYZ_W + 1;

   // ratio divider
   localparam int NUM_W = S_W + PIXEL_FRAC_BITS;
   localparam int DEN_W = XYZ_W;
   localparam int QW    = 41;
   localparam int CMP_W = DEN_W + QW;
   localparam logic [QW-1:0] Q_SAT = QW'(longint'(1) << (QW - 1));

   // lerp fraction, reciprocal multiplication exact for numerators below 2^19
   localparam int LR_W        = 19;
   localparam int T_W         = PIXEL_FRAC_BITS;
   localparam int LERP_SHIFT  = 38;
   localparam int LERP_M_W    = 36;
   localparam int LERP_P_W    = LR_W + LERP_M_W;
   localparam longint LERP_D_VAL = LUM_HI_VAL - LUM_LO_VAL;
   localparam logic [LERP_M_W-1:0] LERP_M =
      LERP_M_W'(((longint'(1) << (LERP_SHIFT + PIXEL_FRAC_BITS)) + LERP_D_VAL - 1)
                / LERP_D_VAL);

   // scotopic factor and divide by 100
   localparam int FN_W        = 49;
   localparam int FM_W        = FN_W - 1;
   localparam int DIG_W       = 8;
   localparam int DIG_STEPS   = FM_W / DIG_W;
   localparam int DIG_R_W     = 7;
   localparam int DIG_RP_W    = DIG_R_W + DIG_W;
   localparam int RECIP_SHIFT = 19;
   localparam int DIG_PROD_W  = DIG_RP_W + 13;
   localparam logic [DIG_PROD_W-1:0] RECIP_100 = DIG_PROD_W'(5243);
   localparam logic [DIG_RP_W-1:0]   DIG_BASE  = DIG_RP_W'(100);
   localparam logic signed [FN_W-1:0] F_GAIN   = FN_W'(133);
   localparam logic signed [FN_W-1:0] F_OFFSET = FN_W'(longint'(35) << PIXEL_FRAC_BITS);

   // scotopic luminance and gray value
   localparam int CLAMP_W = 35;
   localparam int PLO_W   = 18;
   localparam int PHI_W   = CLAMP_W - PLO_W;
   localparam int PROD_W  = 2 * CLAMP_W;
   localparam int YS_W    = 19;
   localparam int G_W     = YS_W + PIX_W - PIXEL_FRAC_BITS;
   localparam int ONE_W   = PIXEL_FRAC_BITS + 1;
   localparam int SAT_IN_W = G_W + 2;

   // input item
   typedef struct packed {
      logic [PIX_W-1:0] in_r;
      logic [PIX_W-1:0] in_g;
      logic [PIX_W-1:0] in_b;
      logic [PIX_W-1:0] out_r;
      logic [PIX_W-1:0] out_g;
      logic [PIX_W-1:0] out_b;
      logic [CRD_W-1:0] pixel_x;
      logic [CRD_W-1:0] pixel_y;
   } msca_req_type;

   // result item
   typedef struct packed {
      logic [PIX_W-1:0] adj_r;
      logic [PIX_W-1:0] adj_g;
      logic [PIX_W-1:0] adj_b;
      logic             was_adjusted;
      logic [CRD_W-1:0] res_x;
      logic [CRD_W-1:0] res_y;
   } msca_rsp_type;

   // data that rides along the pipeline unchanged
   typedef struct packed {
      logic [PIX_W-1:0] px_r;
      logic [PIX_W-1:0] px_g;
      logic [PIX_W-1:0] px_b;
      logic [CRD_W-1:0] pix_x;
      logic [CRD_W-1:0] pix_y;
      logic             photo;
      logic             low;
      logic [XYZ_W-1:0] y_mag;
      logic             y_neg;
   } msca_side_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic             q_neg;
      logic             x_zero;
      logic [LR_W-1:0]  lerp_num;
      msca_side_type    side;
   } msca_div_in_type;

   typedef struct packed {
      logic [QW-1:0]  mag;
      logic           q_neg;
      logic           x_zero;
      logic [T_W-1:0] t;
      msca_side_type  side;
   } msca_div_out_type;

   // clip to the pixel range
   function automatic logic [PIX_W-1:0] sat_pix(input logic [SAT_IN_W-1:0] v);
      logic [PIX_W-1:0] r;
      r = (v > SAT_IN_W'({PIX_W{1'b1}})) ? {PIX_W{1'b1}} : v[PIX_W-1:0];
      return r;
   endfunction

endpackage

@@ hdl/mesopic_scotopic_color_adjust.sv @@
// Night-vision color adjust: takes one item per clock while req_stall is low
// and returns each result in order. Its stages are the ratio divider, which
// resolves one quotient bit per stage over 41 stages, the divide by 100 (six
// 8-bit digit stages) and the multiply stages around them. When a result is
// held by rsp_stall the whole pipeline holds and req_stall is raised. Write
// configuration registers (csr_we/csr_addr/csr_wdata) only while no item is
// in flight (not enforced). gray_level resets to 1.0, all weights to 0.
// ---------------------------------------------------------------------------
// mesopic_scotopic_color_adjust
// Per-pixel scotopic/mesopic color adjustment, fully pipelined.
// ---------------------------------------------------------------------------
`include "mesopic_scotopic_color_adjust_defines.svh"

module mesopic_scotopic_color_adjust (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  msca_pkg::msca_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output msca_pkg::msca_rsp_type              rsp_data,
   input  logic                                csr_we,
   input  logic [msca_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [msca_pkg::CSR_W-1:0]          csr_wdata
);

   typedef struct packed {
      msca_pkg::msca_side_type      side;
      logic [msca_pkg::T_W-1:0]     t;
      logic                         x_zero;
      logic                         fn_neg;
   } back_type;

   // configuration registers
   logic [msca_pkg::CSR_W-1:0] lum_w_ff;
   logic [msca_pkg::CSR_W-1:0] row_ff [0:2];
   logic [msca_pkg::PIX_W-1:0] gray_ff;

   logic en;

   // pipeline registers
   logic                                   a_valid_ff;
   msca_pkg::msca_req_type                 a_req_ff;
   logic                                   b_valid_ff;
   msca_pkg::msca_req_type                 b_req_ff;
   logic [msca_pkg::LUM_PROD_W-1:0]        b_lum_p_ff [0:2];
   logic [msca_pkg::LUM_PROD_W-1:0]        b_lum_p_in [0:2];
   logic signed [msca_pkg::XYZ_PROD_W-1:0] b_xp_ff [0:2][0:2];
   logic signed [msca_pkg::XYZ_PROD_W-1:0] b_xp_in [0:2][0:2];
   logic                                   c_valid_ff;
   msca_pkg::msca_req_type                 c_req_ff;
   logic [msca_pkg::LUM_W-1:0]             c_lum_ff;
   logic [msca_pkg::LUM_W-1:0]             c_lum_in;
   logic signed [msca_pkg::XYZ_W-1:0]      c_xyz_ff [0:2];
   logic signed [msca_pkg::XYZ_W-1:0]      c_xyz_in [0:2];
   logic                                   d_valid_ff;
   msca_pkg::msca_div_in_type              d_div_ff;
   msca_pkg::msca_div_in_type              d_div_in;
   logic                                   div_valid;
   msca_pkg::msca_div_out_type             div_out;
   logic                                   e_valid_ff;
   logic [msca_pkg::FM_W-1:0]              e_fn_ff;
   logic [msca_pkg::FM_W-1:0]              e_fn_in;
   back_type                               e_bk_ff;
   back_type                               e_bk_in;
   logic                                   f_valid_ff [0:msca_pkg::DIG_STEPS-1];
   logic [msca_pkg::FM_W-1:0]              f_n_ff [0:msca_pkg::DIG_STEPS-1];
   logic [msca_pkg::FM_W-1:0]              f_n_in [0:msca_pkg::DIG_STEPS-1];
   logic [msca_pkg::FM_W-1:0]              f_q_ff [0:msca_pkg::DIG_STEPS-1];
   logic [msca_pkg::FM_W-1:0]              f_q_in [0:msca_pkg::DIG_STEPS-1];
   logic [msca_pkg::DIG_R_W-1:0]           f_r_ff [0:msca_pkg::DIG_STEPS-1];
   logic [msca_pkg::DIG_R_W-1:0]           f_r_in [0:msca_pkg::DIG_STEPS-1];
   back_type                               f_bk_ff [0:msca_pkg::DIG_STEPS-1];
   logic                                   g_valid_ff;
   logic [msca_pkg::CLAMP_W+msca_pkg::PLO_W-1:0] g_plo_ff;
   logic [msca_pkg::CLAMP_W+msca_pkg::PHI_W-1:0] g_phi_ff;
   logic [msca_pkg::CLAMP_W+msca_pkg::PLO_W-1:0] g_plo_in;
   logic [msca_pkg::CLAMP_W+msca_pkg::PHI_W-1:0] g_phi_in;
   back_type                               g_bk_ff;
   logic                                   h_valid_ff;
   logic [msca_pkg::YS_W-1:0]              h_ys_ff;
   logic [msca_pkg::YS_W-1:0]              h_ys_in;
   back_type                               h_bk_ff;
   logic                                   i_valid_ff;
   logic [msca_pkg::G_W-1:0]               i_g_ff;
   logic [msca_pkg::G_W-1:0]               i_g_in;
   back_type                               i_bk_ff;
   logic                                   j_valid_ff;
   logic [msca_pkg::G_W+msca_pkg::ONE_W-1:0]  j_gp_ff;
   logic [msca_pkg::G_W+msca_pkg::ONE_W-1:0]  j_gp_in;
   logic [msca_pkg::PIX_W+msca_pkg::T_W-1:0]  j_pp_ff [0:2];
   logic [msca_pkg::PIX_W+msca_pkg::T_W-1:0]  j_pp_in [0:2];
   logic [msca_pkg::G_W-1:0]               j_g_ff;
   back_type                               j_bk_ff;
   logic                                   rsp_valid_ff;
   msca_pkg::msca_rsp_type                 rsp_data_ff;
   msca_pkg::msca_rsp_type                 rsp_data_in;

   // the pipeline moves unless a finished item is held at the output
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lum_w_ff  <= '0;
         row_ff[0] <= '0;
         row_ff[1] <= '0;
         row_ff[2] <= '0;
         gray_ff   <= msca_pkg::GRAY_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            msca_pkg::CSR_LUM_WEIGHTS: lum_w_ff  <= csr_wdata;
            msca_pkg::CSR_XYZ_ROW_X:   row_ff[0] <= csr_wdata;
            msca_pkg::CSR_XYZ_ROW_Y:   row_ff[1] <= csr_wdata;
            msca_pkg::CSR_XYZ_ROW_Z:   row_ff[2] <= csr_wdata;
            msca_pkg::CSR_GRAY_LEVEL:  gray_ff   <= csr_wdata[msca_pkg::PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // luminance and color matrix products
   always_comb begin
      logic [msca_pkg::PIX_W-1:0]             ad [0:2];
      logic [msca_pkg::PIX_W-1:0]             px [0:2];
      logic signed [msca_pkg::XYZ_PROD_W-1:0] cx;
      logic signed [msca_pkg::XYZ_PROD_W-1:0] ps;
      ad[0] = a_req_ff.in_r;
      ad[1] = a_req_ff.in_g;
      ad[2] = a_req_ff.in_b;
      px[0] = a_req_ff.out_r;
      px[1] = a_req_ff.out_g;
      px[2] = a_req_ff.out_b;
      for (int c = 0; c < 3; c++) begin
         b_lum_p_in[c] = msca_pkg::LUM_PROD_W'(lum_w_ff[msca_pkg::COEF_W*c +: msca_pkg::COEF_W])
                       * msca_pkg::LUM_PROD_W'(ad[c]);
         ps = msca_pkg::XYZ_PROD_W'(px[c]);
         for (int r = 0; r < 3; r++) begin
            cx = msca_pkg::XYZ_PROD_W'(
                    $signed(row_ff[r][msca_pkg::COEF_W*c +: msca_pkg::COEF_W]));
            b_xp_in[r][c] = cx * ps;
         end
      end
   end

   // sums, then scale back to pixel format
   always_comb begin
      logic [msca_pkg::LUM_SUM_W-1:0]        lsum;
      logic signed [msca_pkg::XYZ_SUM_W-1:0] xsum;
      lsum = msca_pkg::LUM_SUM_W'(b_lum_p_ff[0]) + msca_pkg::LUM_SUM_W'(b_lum_p_ff[1])
           + msca_pkg::LUM_SUM_W'(b_lum_p_ff[2]);
      c_lum_in = msca_pkg::LUM_W'(lsum >> msca_pkg::COEF_FRAC_BITS);
      for (int r = 0; r < 3; r++) begin
         xsum = msca_pkg::XYZ_SUM_W'(b_xp_ff[r][0]) + msca_pkg::XYZ_SUM_W'(b_xp_ff[r][1])
              + msca_pkg::XYZ_SUM_W'(b_xp_ff[r][2]);
         c_xyz_in[r] = msca_pkg::XYZ_W'(xsum >>> msca_pkg::COEF_FRAC_BITS);
      end
   end

   // divider operands, magnitudes and signs
   always_comb begin
      logic signed [msca_pkg::S_W-1:0] s;
      logic [msca_pkg::S_W-1:0]        abs_s;
      s = msca_pkg::S_W'(c_xyz_ff[1]) + msca_pkg::S_W'(c_xyz_ff[2]);
      abs_s = s[msca_pkg::S_W-1] ? msca_pkg::S_W'(-s) : msca_pkg::S_W'(s);
      d_div_in.num    = msca_pkg::NUM_W'(abs_s) << msca_pkg::PIXEL_FRAC_BITS;
      d_div_in.den    = c_xyz_ff[0][msca_pkg::XYZ_W-1] ?
                        msca_pkg::DEN_W'(-c_xyz_ff[0]) : msca_pkg::DEN_W'(c_xyz_ff[0]);
      d_div_in.q_neg  = s[msca_pkg::S_W-1] ^ c_xyz_ff[0][msca_pkg::XYZ_W-1];
      d_div_in.x_zero = (c_xyz_ff[0] == '0);
      d_div_in.side.px_r  = c_req_ff.out_r;
      d_div_in.side.px_g  = c_req_ff.out_g;
      d_div_in.side.px_b  = c_req_ff.out_b;
      d_div_in.side.pix_x = c_req_ff.pixel_x;
      d_div_in.side.pix_y = c_req_ff.pixel_y;
      d_div_in.side.photo = (c_lum_ff >= msca_pkg::LUM_HI);
      d_div_in.side.low   = (c_lum_ff < msca_pkg::LUM_LO);
      d_div_in.side.y_mag = c_xyz_ff[1][msca_pkg::XYZ_W-1] ?
                            msca_pkg::XYZ_W'(-c_xyz_ff[1]) : msca_pkg::XYZ_W'(c_xyz_ff[1]);
      d_div_in.side.y_neg = c_xyz_ff[1][msca_pkg::XYZ_W-1];
      d_div_in.lerp_num   = (d_div_in.side.photo || d_div_in.side.low) ? '0 :
                            msca_pkg::LR_W'(c_lum_ff - msca_pkg::LUM_LO);
   end

   // front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_req_ff   <= req_data;
         b_req_ff   <= a_req_ff;
         b_lum_p_ff <= b_lum_p_in;
         b_xp_ff    <= b_xp_in;
         c_req_ff   <= b_req_ff;
         c_lum_ff   <= c_lum_in;
         c_xyz_ff   <= c_xyz_in;
         d_div_ff   <= d_div_in;
      end
   end

   // ratio and lerp fraction
   msca_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid_ff),
      .in_data   (d_div_ff),
      .out_valid (div_valid),
      .out_data  (div_out)
   );

   // scotopic factor numerator 133*(1+q) - 168
   always_comb begin
      logic signed [msca_pkg::FN_W-1:0] qs;
      logic signed [msca_pkg::FN_W-1:0] fnum;
      qs = div_out.q_neg ? -$signed(msca_pkg::FN_W'(div_out.mag)) :
                            $signed(msca_pkg::FN_W'(div_out.mag));
      fnum = qs * msca_pkg::F_GAIN - msca_pkg::F_OFFSET;
      e_fn_in = fnum[msca_pkg::FN_W-1] ? msca_pkg::FM_W'(-fnum) : msca_pkg::FM_W'(fnum);
      e_bk_in.side   = div_out.side;
      e_bk_in.t      = div_out.t;
      e_bk_in.x_zero = div_out.x_zero;
      e_bk_in.fn_neg = fnum[msca_pkg::FN_W-1];
   end

   // divide by 100, one byte per stage
   always_comb begin
      logic [msca_pkg::FM_W-1:0]       n_prev;
      logic [msca_pkg::FM_W-1:0]       q_prev;
      logic [msca_pkg::DIG_R_W-1:0]    r_prev;
      logic [msca_pkg::DIG_RP_W-1:0]   rp;
      logic [msca_pkg::DIG_PROD_W-1:0] prod;
      logic [msca_pkg::DIG_W-1:0]      qd;
      for (int j = 0; j < msca_pkg::DIG_STEPS; j++) begin
         if (j == 0) begin
            n_prev = e_fn_ff;
            q_prev = '0;
            r_prev = '0;
         end else begin
            n_prev = f_n_ff[j-1];
            q_prev = f_q_ff[j-1];
            r_prev = f_r_ff[j-1];
         end
         rp   = {r_prev, n_prev[msca_pkg::FM_W-1 -: msca_pkg::DIG_W]};
         prod = msca_pkg::DIG_PROD_W'(rp) * msca_pkg::RECIP_100;
         qd   = prod[msca_pkg::RECIP_SHIFT +: msca_pkg::DIG_W];
         f_r_in[j] = msca_pkg::DIG_R_W'(rp - msca_pkg::DIG_RP_W'(qd) * msca_pkg::DIG_BASE);
         f_q_in[j] = {q_prev[msca_pkg::FM_W-msca_pkg::DIG_W-1:0], qd};
         f_n_in[j] = n_prev << msca_pkg::DIG_W;
      end
   end

   // clamp both factors, split product
   always_comb begin
      logic [msca_pkg::CLAMP_W-1:0] ymc;
      logic [msca_pkg::CLAMP_W-1:0] fmc;
      logic [msca_pkg::FM_W-1:0]    fm;
      fm  = f_q_ff[msca_pkg::DIG_STEPS-1];
      ymc = (f_bk_ff[msca_pkg::DIG_STEPS-1].side.y_mag >
             msca_pkg::XYZ_W'({msca_pkg::CLAMP_W{1'b1}})) ? {msca_pkg::CLAMP_W{1'b1}} :
            f_bk_ff[msca_pkg::DIG_STEPS-1].side.y_mag[msca_pkg::CLAMP_W-1:0];
      fmc = (fm > msca_pkg::FM_W'({msca_pkg::CLAMP_W{1'b1}})) ? {msca_pkg::CLAMP_W{1'b1}} :
            fm[msca_pkg::CLAMP_W-1:0];
      g_plo_in = msca_pkg::CLAMP_W'(ymc) * (msca_pkg::CLAMP_W+msca_pkg::PLO_W)'(
                    fmc[msca_pkg::PLO_W-1:0]);
      g_phi_in = (msca_pkg::CLAMP_W+msca_pkg::PHI_W)'(ymc) *
                 (msca_pkg::CLAMP_W+msca_pkg::PHI_W)'(fmc[msca_pkg::CLAMP_W-1:msca_pkg::PLO_W]);
   end

   // scotopic luminance, bounded to the photopic limit
   always_comb begin
      logic [msca_pkg::PROD_W-1:0] prod;
      logic [msca_pkg::PROD_W-1:0] sh;
      prod = msca_pkg::PROD_W'(g_plo_ff) + (msca_pkg::PROD_W'(g_phi_ff) << msca_pkg::PLO_W);
      sh   = prod >> msca_pkg::PIXEL_FRAC_BITS;
      if (g_bk_ff.x_zero) begin
         h_ys_in = msca_pkg::YS_W'(msca_pkg::LUM_HI);
      end else if (g_bk_ff.fn_neg ^ g_bk_ff.side.y_neg) begin
         h_ys_in = '0;
      end else if (sh >= msca_pkg::PROD_W'(msca_pkg::LUM_HI)) begin
         h_ys_in = msca_pkg::YS_W'(msca_pkg::LUM_HI);
      end else begin
         h_ys_in = sh[msca_pkg::YS_W-1:0];
      end
   end

   // gray value
   always_comb begin
      logic [msca_pkg::YS_W+msca_pkg::PIX_W-1:0] gf;
      gf     = (msca_pkg::YS_W+msca_pkg::PIX_W)'(h_ys_ff) *
               (msca_pkg::YS_W+msca_pkg::PIX_W)'(gray_ff);
      i_g_in = msca_pkg::G_W'(gf >> msca_pkg::PIXEL_FRAC_BITS);
   end

   // lerp products
   always_comb begin
      logic [msca_pkg::ONE_W-1:0] one_m_t;
      logic [msca_pkg::PIX_W-1:0] px [0:2];
      one_m_t = (msca_pkg::ONE_W'(1) << msca_pkg::PIXEL_FRAC_BITS) - msca_pkg::ONE_W'(i_bk_ff.t);
      px[0] = i_bk_ff.side.px_r;
      px[1] = i_bk_ff.side.px_g;
      px[2] = i_bk_ff.side.px_b;
      j_gp_in = (msca_pkg::G_W+msca_pkg::ONE_W)'(i_g_ff) *
                (msca_pkg::G_W+msca_pkg::ONE_W)'(one_m_t);
      for (int c = 0; c < 3; c++) begin
         j_pp_in[c] = (msca_pkg::PIX_W+msca_pkg::T_W)'(px[c]) *
                      (msca_pkg::PIX_W+msca_pkg::T_W)'(i_bk_ff.t);
      end
   end

   // result selection
   always_comb begin
      logic [msca_pkg::SAT_IN_W-1:0] v [0:2];
      logic [msca_pkg::SAT_IN_W-1:0] gs;
      gs = msca_pkg::SAT_IN_W'(j_g_ff);
      for (int c = 0; c < 3; c++) begin
         v[c] = msca_pkg::SAT_IN_W'((msca_pkg::SAT_IN_W+msca_pkg::PIXEL_FRAC_BITS)'(j_gp_ff)
                + (msca_pkg::SAT_IN_W+msca_pkg::PIXEL_FRAC_BITS)'(j_pp_ff[c])
                >> msca_pkg::PIXEL_FRAC_BITS);
      end
      rsp_data_in.res_x = j_bk_ff.side.pix_x;
      rsp_data_in.res_y = j_bk_ff.side.pix_y;
      if (j_bk_ff.side.photo) begin
         rsp_data_in.adj_r        = j_bk_ff.side.px_r;
         rsp_data_in.adj_g        = j_bk_ff.side.px_g;
         rsp_data_in.adj_b        = j_bk_ff.side.px_b;
         rsp_data_in.was_adjusted = 1'b0;
      end else if (j_bk_ff.side.low) begin
         rsp_data_in.adj_r        = msca_pkg::sat_pix(gs);
         rsp_data_in.adj_g        = msca_pkg::sat_pix(gs);
         rsp_data_in.adj_b        = msca_pkg::sat_pix(gs);
         rsp_data_in.was_adjusted = 1'b1;
      end else begin
         rsp_data_in.adj_r        = msca_pkg::sat_pix(v[0]);
         rsp_data_in.adj_g        = msca_pkg::sat_pix(v[1]);
         rsp_data_in.adj_b        = msca_pkg::sat_pix(v[2]);
         rsp_data_in.was_adjusted = 1'b1;
      end
   end

   // back stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         for (int j = 0; j < msca_pkg::DIG_STEPS; j++) f_valid_ff[j] <= 1'b0;
         g_valid_ff   <= 1'b0;
         h_valid_ff   <= 1'b0;
         i_valid_ff   <= 1'b0;
         j_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff    <= div_valid;
         f_valid_ff[0] <= e_valid_ff;
         for (int j = 1; j < msca_pkg::DIG_STEPS; j++) f_valid_ff[j] <= f_valid_ff[j-1];
         g_valid_ff    <= f_valid_ff[msca_pkg::DIG_STEPS-1];
         h_valid_ff    <= g_valid_ff;
         i_valid_ff    <= h_valid_ff;
         j_valid_ff    <= i_valid_ff;
         rsp_valid_ff  <= j_valid_ff;
      end
   end

   // back stage data
   always_ff @(posedge clock) begin
      if (en) begin
         e_fn_ff    <= e_fn_in;
         e_bk_ff    <= e_bk_in;
         f_bk_ff[0] <= e_bk_ff;
         for (int j = 0; j < msca_pkg::DIG_STEPS; j++) begin
            f_n_ff[j] <= f_n_in[j];
            f_q_ff[j] <= f_q_in[j];
            f_r_ff[j] <= f_r_in[j];
         end
         for (int j = 1; j < msca_pkg::DIG_STEPS; j++) f_bk_ff[j] <= f_bk_ff[j-1];
         g_plo_ff    <= g_plo_in;
         g_phi_ff    <= g_phi_in;
         g_bk_ff     <= f_bk_ff[msca_pkg::DIG_STEPS-1];
         h_ys_ff     <= h_ys_in;
         h_bk_ff     <= g_bk_ff;
         i_g_ff      <= i_g_in;
         i_bk_ff     <= h_bk_ff;
         j_gp_ff     <= j_gp_in;
         j_pp_ff     <= j_pp_in;
         j_g_ff      <= i_g_ff;
         j_bk_ff     <= i_bk_ff;
         rsp_data_ff <= rsp_data_in;
      end
   end

   // checks
   `MSCA_ASSERT_IMPL(a_mag_cap, clock, reset, div_valid, div_out.mag <= msca_pkg::Q_SAT)
   `MSCA_ASSERT_IMPL(a_ys_cap, clock, reset, h_valid_ff, h_ys_ff <= msca_pkg::YS_W'(msca_pkg::LUM_HI))
   `MSCA_ASSERT_NEXT(a_photo_pass, clock, reset, en && j_valid_ff && j_bk_ff.side.photo, rsp_valid_ff && !rsp_data_ff.was_adjusted)

endmodule

@@ hdl/msca_div_pipe.sv @@
// ---------------------------------------------------------------------------
// msca_div_pipe
// Pipelined restoring divider, one quotient bit per stage, for the ratio
// (Y+Z)/X with saturation; the lerp fraction is formed at entry by a
// reciprocal multiplication and rides along.
// ---------------------------------------------------------------------------
module msca_div_pipe (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  msca_pkg::msca_div_in_type  in_data,
   output logic                       out_valid,
   output msca_pkg::msca_div_out_type out_data
);

   typedef struct packed {
      logic [msca_pkg::NUM_W-1:0] rem;
      logic [msca_pkg::DEN_W-1:0] den;
      logic [msca_pkg::QW-1:0]    quo;
      logic                       sat;
      logic                       q_neg;
      logic                       x_zero;
      logic [msca_pkg::T_W-1:0]   t;
      msca_pkg::msca_side_type    side;
   } stage_type;

   stage_type st_ff [0:msca_pkg::QW];
   stage_type st_in [0:msca_pkg::QW];
   logic      valid_ff [0:msca_pkg::QW];

   // entry check, lerp fraction and one quotient bit per stage
   always_comb begin
      logic [msca_pkg::CMP_W-1:0]    cmp;
      logic [msca_pkg::LERP_P_W-1:0] lp;
      stage_type                     nxt;
      lp = msca_pkg::LERP_P_W'(in_data.lerp_num) * msca_pkg::LERP_P_W'(msca_pkg::LERP_M);
      st_in[0].rem    = in_data.num;
      st_in[0].den    = in_data.den;
      st_in[0].quo    = '0;
      st_in[0].sat    = msca_pkg::CMP_W'(in_data.num) >=
                        (msca_pkg::CMP_W'(in_data.den) << msca_pkg::QW);
      st_in[0].q_neg  = in_data.q_neg;
      st_in[0].x_zero = in_data.x_zero;
      st_in[0].t      = lp[msca_pkg::LERP_SHIFT +: msca_pkg::T_W];
      st_in[0].side   = in_data.side;
      for (int i = 0; i < msca_pkg::QW; i++) begin
         nxt = st_ff[i];
         cmp = msca_pkg::CMP_W'(st_ff[i].den) << (msca_pkg::QW - 1 - i);
         if (msca_pkg::CMP_W'(st_ff[i].rem) >= cmp) begin
            nxt.rem = st_ff[i].rem - cmp[msca_pkg::NUM_W-1:0];
            nxt.quo = {st_ff[i].quo[msca_pkg::QW-2:0], 1'b1};
         end else begin
            nxt.quo = {st_ff[i].quo[msca_pkg::QW-2:0], 1'b0};
         end
         st_in[i+1] = nxt;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= msca_pkg::QW; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int i = 0; i < msca_pkg::QW; i++) valid_ff[i+1] <= valid_ff[i];
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= msca_pkg::QW; i++) st_ff[i] <= st_in[i];
      end
   end

   // saturate the quotient at the cap
   assign out_valid       = valid_ff[msca_pkg::QW];
   assign out_data.mag    = (st_ff[msca_pkg::QW].sat ||
                             st_ff[msca_pkg::QW].quo > msca_pkg::Q_SAT) ?
                            msca_pkg::Q_SAT : st_ff[msca_pkg::QW].quo;
   assign out_data.q_neg  = st_ff[msca_pkg::QW].q_neg;
   assign out_data.x_zero = st_ff[msca_pkg::QW].x_zero;
   assign out_data.t      = st_ff[msca_pkg::QW].t;
   assign out_data.side   = st_ff[msca_pkg::QW].side;

endmodule
